[hw/rtl/swhsr_pkg.sv]
package swhsr_pkg;

  // Configuration port geometry
  localparam int CfgDataW = 20;
  localparam int CfgIdxW  = 3;
  localparam int TickW    = 20;
  localparam int ShortW   = 10;

  // Register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_WARMUP      = 3'd0,
    CFG_START_LOW   = 3'd1,
    CFG_REL_HIGH    = 3'd2,
    CFG_RESP_SAMPLE = 3'd3,
    CFG_RESP_CHECK  = 3'd4,
    CFG_BIT_SAMPLE  = 3'd5,
    CFG_FRAME_BYTES = 3'd6
  } cfg_idx_t;

  // Register reset values
  localparam logic [TickW-1:0]  WarmupRst      = 20'd200000;
  localparam logic [TickW-1:0]  StartLowRst    = 20'd5000;
  localparam logic [ShortW-1:0] RelHighRst     = 10'd20;
  localparam logic [ShortW-1:0] RespSampleRst  = 10'd40;
  localparam logic [ShortW-1:0] RespCheckRst   = 10'd80;
  localparam logic [ShortW-1:0] BitSampleRst   = 10'd40;
  localparam logic [3:0]        FrameBytesRst  = 4'd5;

  // Response status codes
  typedef enum logic [1:0] {
    STAT_PENDING = 2'd0,
    STAT_OK      = 2'd1,
    STAT_NO_RESP = 2'd2,
    STAT_BAD     = 2'd3
  } status_t;

  typedef struct packed {
    logic func;
    logic line_level;
  } item_t;

  typedef struct packed {
    logic       drive_enable;
    logic       drive_level;
    logic       byte_valid;
    logic [7:0] data_byte;
    logic       frame_last;
    logic [1:0] response_status;
    logic       busy_res;
  } result_t;

endpackage

[hw/rtl/swhsr_in_if.sv]
interface swhsr_in_if;
  logic valid;
  logic ready;
  logic func;
  logic line_level;

  modport source (output valid, output func, output line_level, input ready);
  modport sink (input valid, input func, input line_level, output ready);
endinterface

[hw/rtl/swhsr_out_if.sv]
interface swhsr_out_if;
  logic       valid;
  logic       ready;
  logic       drive_enable;
  logic       drive_level;
  logic       byte_valid;
  logic [7:0] data_byte;
  logic       frame_last;
  logic [1:0] response_status;
  logic       busy_res;

  modport source (
    output valid, output drive_enable, output drive_level, output byte_valid,
    output data_byte, output frame_last, output response_status, output busy_res,
    input ready
  );
  modport sink (
    input valid, input drive_enable, input drive_level, input byte_valid,
    input data_byte, input frame_last, input response_status, input busy_res,
    output ready
  );
endinterface

[hw/rtl/swhsr_step.sv]
module swhsr_step
  import swhsr_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_idx,
  input  logic [CfgDataW-1:0] cfg_wdata,
  input  logic                step_en,
  input  item_t               item,
  output result_t             res
);

  typedef enum logic [3:0] {
    PH_IDLE     = 4'd0,
    PH_WARMUP   = 4'd1,
    PH_STARTLOW = 4'd2,
    PH_RELHIGH  = 4'd3,
    PH_RESP1    = 4'd4,
    PH_RESP2    = 4'd5,
    PH_WAITLOW  = 4'd6,
    PH_WAITRISE = 4'd7,
    PH_BITSAMP  = 4'd8,
    PH_WAITFALL = 4'd9
  } phase_t;

  logic [TickW-1:0]  warmup_r;
  logic [TickW-1:0]  start_low_r;
  logic [ShortW-1:0] rel_high_r;
  logic [ShortW-1:0] resp_sample_r;
  logic [ShortW-1:0] resp_check_r;
  logic [ShortW-1:0] bit_sample_r;
  logic [3:0]        frame_bytes_r;

  phase_t      phase_r, phase_nxt;
  logic [TickW-1:0] tick_r, tick_nxt;
  logic [7:0]  shift_r, shift_nxt;
  logic [2:0]  bit_idx_r, bit_idx_nxt;
  logic [2:0]  byte_idx_r, byte_idx_nxt;
  logic [1:0]  status_r, status_nxt;

  logic [TickW-1:0] tick_inc;
  logic [TickW-1:0] target;
  logic             timer_done;
  logic [3:0]       frame_lim;
  logic [3:0]       byte_cnt;
  logic             byte_done;
  logic [7:0]       byte_out;
  logic             frame_end;

  // Configuration writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      warmup_r      <= WarmupRst;
      start_low_r   <= StartLowRst;
      rel_high_r    <= RelHighRst;
      resp_sample_r <= RespSampleRst;
      resp_check_r  <= RespCheckRst;
      bit_sample_r  <= BitSampleRst;
      frame_bytes_r <= FrameBytesRst;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_WARMUP:      warmup_r      <= cfg_wdata;
        CFG_START_LOW:   start_low_r   <= cfg_wdata;
        CFG_REL_HIGH:    rel_high_r    <= cfg_wdata[ShortW-1:0];
        CFG_RESP_SAMPLE: resp_sample_r <= cfg_wdata[ShortW-1:0];
        CFG_RESP_CHECK:  resp_check_r  <= cfg_wdata[ShortW-1:0];
        CFG_BIT_SAMPLE:  bit_sample_r  <= cfg_wdata[ShortW-1:0];
        CFG_FRAME_BYTES: frame_bytes_r <= cfg_wdata[3:0];
        default: ;
      endcase
    end
  end

  // Select the time limit of the current timed phase
  always_comb begin
    case (phase_r)
      PH_WARMUP:   target = warmup_r;
      PH_STARTLOW: target = start_low_r;
      PH_RELHIGH:  target = {{(TickW-ShortW){1'b0}}, rel_high_r};
      PH_RESP1:    target = {{(TickW-ShortW){1'b0}}, resp_sample_r};
      PH_RESP2:    target = {{(TickW-ShortW){1'b0}}, resp_check_r};
      default:     target = {{(TickW-ShortW){1'b0}}, bit_sample_r};
    endcase
  end

  // Zero-length timing counts as one tick, so a wrapped count also ends the phase
  assign tick_inc   = tick_r + TickW'(1);
  assign timer_done = (tick_inc >= target) || (tick_inc == '0);

  // Clamp frame length to one through eight bytes
  always_comb begin
    if (frame_bytes_r == 4'd0)      frame_lim = 4'd1;
    else if (frame_bytes_r > 4'd8)  frame_lim = 4'd8;
    else                            frame_lim = frame_bytes_r;
  end

  assign byte_cnt = {1'b0, byte_idx_r} + 4'd1;

  // Next state for one tick or start command
  always_comb begin
    phase_nxt    = phase_r;
    tick_nxt     = tick_r;
    shift_nxt    = shift_r;
    bit_idx_nxt  = bit_idx_r;
    byte_idx_nxt = byte_idx_r;
    status_nxt   = status_r;
    byte_done    = 1'b0;
    byte_out     = 8'd0;
    frame_end    = 1'b0;
    if (item.func) begin
      phase_nxt    = PH_WARMUP;
      tick_nxt     = '0;
      shift_nxt    = 8'd0;
      bit_idx_nxt  = 3'd0;
      byte_idx_nxt = 3'd0;
      status_nxt   = STAT_PENDING;
    end else begin
      case (phase_r)
        PH_IDLE: ;
        PH_WARMUP, PH_STARTLOW, PH_RELHIGH: begin
          tick_nxt = timer_done ? '0 : tick_inc;
          if (timer_done) begin
            phase_nxt = phase_t'(phase_r + 4'd1);
          end
        end
        PH_RESP1: begin
          tick_nxt = timer_done ? '0 : tick_inc;
          if (timer_done) begin
            if (!item.line_level) begin
              phase_nxt = PH_RESP2;
            end else begin
              status_nxt = STAT_NO_RESP;
              phase_nxt  = PH_WAITLOW;
            end
          end
        end
        PH_RESP2: begin
          tick_nxt = timer_done ? '0 : tick_inc;
          if (timer_done) begin
            status_nxt = item.line_level ? STAT_OK : STAT_BAD;
            phase_nxt  = PH_WAITLOW;
          end
        end
        PH_WAITLOW: begin
          if (!item.line_level) phase_nxt = PH_WAITRISE;
        end
        PH_WAITRISE: begin
          if (item.line_level) begin
            tick_nxt  = '0;
            phase_nxt = PH_BITSAMP;
          end
        end
        PH_BITSAMP: begin
          tick_nxt = timer_done ? '0 : tick_inc;
          if (timer_done) begin
            shift_nxt[3'd7 - bit_idx_r] = item.line_level;
            phase_nxt = PH_WAITFALL;
          end
        end
        PH_WAITFALL: begin
          if (!item.line_level) begin
            if (bit_idx_r == 3'd7) begin
              byte_done   = 1'b1;
              byte_out    = shift_r;
              bit_idx_nxt = 3'd0;
              shift_nxt   = 8'd0;
              if (byte_cnt >= frame_lim) begin
                frame_end    = 1'b1;
                byte_idx_nxt = 3'd0;
                phase_nxt    = PH_IDLE;
              end else begin
                byte_idx_nxt = byte_cnt[2:0];
                phase_nxt    = PH_WAITRISE;
              end
            end else begin
              bit_idx_nxt = bit_idx_r + 3'd1;
              phase_nxt   = PH_WAITRISE;
            end
          end
        end
        default: phase_nxt = PH_IDLE;
      endcase
    end
  end

  // Hold state; advance on each processed item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      tick_r     <= '0;
      shift_r    <= 8'd0;
      bit_idx_r  <= 3'd0;
      byte_idx_r <= 3'd0;
      status_r   <= STAT_PENDING;
    end else if (step_en) begin
      phase_r    <= phase_nxt;
      tick_r     <= tick_nxt;
      shift_r    <= shift_nxt;
      bit_idx_r  <= bit_idx_nxt;
      byte_idx_r <= byte_idx_nxt;
      status_r   <= status_nxt;
    end
  end

  // Result from the state after this step
  always_comb begin
    res.drive_enable    = (phase_nxt == PH_WARMUP) || (phase_nxt == PH_RELHIGH) ||
                          (phase_nxt == PH_STARTLOW);
    res.drive_level     = (phase_nxt == PH_WARMUP) || (phase_nxt == PH_RELHIGH);
    res.byte_valid      = byte_done;
    res.data_byte       = byte_out;
    res.frame_last      = frame_end;
    res.response_status = status_nxt;
    res.busy_res        = (phase_nxt != PH_IDLE);
  end

endmodule

[hw/rtl/single_wire_humidity_sensor_reader_core.sv]
// Single-wire humidity sensor reader.
// Input channel (in_if): one item per microsecond; func = 0 is a tick with
// the sampled line level, func = 1 starts a new read and aborts any read in
// progress. Result channel (out_if): exactly one result per input item, with
// the line drive controls, a received byte when one completes (MSB first,
// frame_last on the final byte), the response status and a busy flag.
// Configuration: cfg_we/cfg_idx/cfg_wdata write one timing register per
// cycle; write only while no transfer is in flight.
// Path: an item transferred in is held in the input register, then its result
// is captured in the result register and offered on out_if.
// Throughput: one item per cycle while out_if.ready stays high; the single-pass
// step logic between the two registers sets this figure.
// Stall: when out_if.ready is low the result register holds; one more item
// is taken into the input register, then in_if.ready drops.
// Reset (rst_n low, synchronous): both channels empty, state idle, status
// pending, and all timing registers return to their defaults.
module single_wire_humidity_sensor_reader_core
  import swhsr_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_idx,
  input  logic [CfgDataW-1:0] cfg_wdata,
  swhsr_in_if.sink            in_if,
  swhsr_out_if.source         out_if
);

  logic    in_v_r;
  item_t   in_item_r;
  logic    out_v_r;
  result_t out_res_r;
  result_t step_res;
  logic    adv;

  // Move the held item into the result register when it is free
  assign adv         = in_v_r && (!out_v_r || out_if.ready);
  assign in_if.ready = !in_v_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_if.ready) begin
      in_v_r <= in_if.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.ready && in_if.valid) begin
      in_item_r.func       <= in_if.func;
      in_item_r.line_level <= in_if.line_level;
    end
  end

  swhsr_step u_step (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .step_en   (adv),
    .item      (in_item_r),
    .res       (step_res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= 1'b1;
    end else if (out_if.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_res_r <= step_res;
    end
  end

  assign out_if.valid           = out_v_r;
  assign out_if.drive_enable    = out_res_r.drive_enable;
  assign out_if.drive_level     = out_res_r.drive_level;
  assign out_if.byte_valid      = out_res_r.byte_valid;
  assign out_if.data_byte       = out_res_r.data_byte;
  assign out_if.frame_last      = out_res_r.frame_last;
  assign out_if.response_status = out_res_r.response_status;
  assign out_if.busy_res        = out_res_r.busy_res;

endmodule

[hw/rtl/swhsr_checker.sv]
module swhsr_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic       drive_enable,
  input logic       drive_level,
  input logic       byte_valid,
  input logic [7:0] data_byte,
  input logic       frame_last,
  input logic       busy_res
);

  // Result channel comes out of reset empty
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // Stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(data_byte) && $stable(byte_valid))
    else $error("stalled result changed");

  // No byte data without a completed byte
  a_byte_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !byte_valid |-> data_byte == 8'd0 && !frame_last)
    else $error("byte fields set without byte_valid");

  // Line is only driven high while driving and while busy
  a_drive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && drive_level |-> drive_enable && busy_res)
    else $error("drive_level without drive_enable");

  // Last byte of a frame ends the transaction
  a_frame_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && frame_last |-> byte_valid && !busy_res && !drive_enable)
    else $error("frame_last without end of transaction");

endmodule

bind single_wire_humidity_sensor_reader_core swhsr_checker u_swhsr_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_if.valid),
  .out_ready    (out_if.ready),
  .drive_enable (out_if.drive_enable),
  .drive_level  (out_if.drive_level),
  .byte_valid   (out_if.byte_valid),
  .data_byte    (out_if.data_byte),
  .frame_last   (out_if.frame_last),
  .busy_res     (out_if.busy_res)
);
